// ===== rtl/dfe_pkg.sv =====
// Package for the delimited frame extractor.
// Holds the result type, register indexes, reset values and queue sizing.
// No dependencies.
package dfe_pkg;

    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 8;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_HEAD_CHAR     = 2'd0,
        CFG_TAIL_FIRST    = 2'd1,
        CFG_TAIL_SECOND   = 2'd2,
        CFG_MAX_FRAME_LEN = 2'd3
    } cfg_idx_t;

    localparam logic [7:0] HeadCharReset    = 8'd36;
    localparam logic [7:0] TailFirstReset   = 8'd13;
    localparam logic [7:0] TailSecondReset  = 8'd10;
    localparam logic [7:0] MaxFrameLenReset = 8'd220;
    localparam logic [7:0] MinFrameLen      = 8'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       abort;
    } frame_res_t;

    localparam frame_res_t AbortRes = '{data: 8'd0, first: 1'b0, last: 1'b0, abort: 1'b1};

endpackage

// ===== rtl/delimited_frame_extractor.sv =====
// Delimited frame extractor top level.
// Depends on dfe_pkg for the result type, register indexes and reset values.
//
// Usage: received bytes enter on the rx_byte channel (in_valid/in_ready).
// Bytes before a head byte are dropped. From the head on, every frame byte
// leaves at once on the result channel (out_valid/out_ready) with
// frame_first on the head and frame_last on the byte that completes the
// two-byte tail. A result with frame_abort set carries no byte and marks
// the frame so far as dropped: it is sent when a head byte arrives inside
// a frame, or when it reaches max_frame_len (at least 3) bytes without its tail.
// Each request is decoded in the cycle it is accepted and its zero, one or
// two results are written into a four-entry result queue, which registers
// each result before it is offered. One request is taken per cycle
// while the queue has room for two results; the one result port limits
// the sustained rate to one result per cycle. When the receiver stalls,
// the queue fills and in_ready drops until two entries are free.
// Reset empties the queue, returns to hunting for a head and loads the
// default registers ('$', CR, LF, 220). Registers are written through
// cfg_we/cfg_index/cfg_data and take effect from the next request.
module delimited_frame_extractor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    frame_byte,
    output logic                          frame_first,
    output logic                          frame_last,
    output logic                          frame_abort,
    input  logic                          cfg_we,
    input  logic [dfe_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [dfe_pkg::CfgDataW-1:0]  cfg_data
);
    import dfe_pkg::*;

    logic [7:0] head_char_reg;
    logic [7:0] tail_first_reg;
    logic [7:0] tail_second_reg;
    logic [7:0] max_len_reg;

    logic       in_frame_reg,  in_frame_next;
    logic [7:0] count_reg,     count_next;
    logic       prev_tail_reg, prev_tail_next;

    frame_res_t              queue_reg [QueueDepth];
    logic [QueuePtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QueueCntW-1:0]    fill_reg, fill_next;

    frame_res_t  res0, res1;
    logic [1:0]  n_res;
    logic [7:0]  lim;
    logic [7:0]  count_inc;
    logic        accept;
    logic        pop;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            head_char_reg   <= HeadCharReset;
            tail_first_reg  <= TailFirstReset;
            tail_second_reg <= TailSecondReset;
            max_len_reg     <= MaxFrameLenReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HEAD_CHAR:     head_char_reg   <= cfg_data;
                CFG_TAIL_FIRST:    tail_first_reg  <= cfg_data;
                CFG_TAIL_SECOND:   tail_second_reg <= cfg_data;
                CFG_MAX_FRAME_LEN: max_len_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign lim       = (max_len_reg < MinFrameLen) ? MinFrameLen : max_len_reg;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        res0           = AbortRes;
        res1           = AbortRes;
        n_res          = 2'd0;
        in_frame_next  = in_frame_reg;
        count_next     = count_reg;
        prev_tail_next = prev_tail_reg;
        if (!in_frame_reg)
        begin
            if (rx_byte == head_char_reg)
            begin
                res0           = '{data: rx_byte, first: 1'b1, last: 1'b0, abort: 1'b0};
                n_res          = 2'd1;
                in_frame_next  = 1'b1;
                count_next     = 8'd1;
                prev_tail_next = 1'b0;
            end
        end
        else if (prev_tail_reg && rx_byte == tail_second_reg && count_reg < lim)
        begin
            res0           = '{data: rx_byte, first: 1'b0, last: 1'b1, abort: 1'b0};
            n_res          = 2'd1;
            in_frame_next  = 1'b0;
            count_next     = 8'd0;
            prev_tail_next = 1'b0;
        end
        else if (rx_byte == head_char_reg)
        begin
            res1           = '{data: rx_byte, first: 1'b1, last: 1'b0, abort: 1'b0};
            n_res          = 2'd2;
            count_next     = 8'd1;
            prev_tail_next = 1'b0;
        end
        else if (count_reg >= lim)
        begin
            n_res          = 2'd1;
            in_frame_next  = 1'b0;
            count_next     = 8'd0;
            prev_tail_next = 1'b0;
        end
        else
        begin
            res0 = '{data: rx_byte, first: 1'b0, last: 1'b0, abort: 1'b0};
            if (count_inc >= lim)
            begin
                n_res          = 2'd2;
                in_frame_next  = 1'b0;
                count_next     = 8'd0;
                prev_tail_next = 1'b0;
            end
            else
            begin
                n_res          = 2'd1;
                count_next     = count_inc;
                prev_tail_next = (rx_byte == tail_first_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= 8'd0;
            prev_tail_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_frame_reg  <= in_frame_next;
            count_reg     <= count_next;
            prev_tail_reg <= prev_tail_next;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            fill_next = fill_next + QueueCntW'(n_res);
        end
        if (pop)
        begin
            fill_next = fill_next - QueueCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + QueuePtrW'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QueuePtrW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept && n_res != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && n_res == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QueuePtrW'(1)] <= res1;
        end
    end

    assign in_ready    = (fill_reg <= QueueCntW'(QueueDepth - 2));
    assign out_valid   = (fill_reg != '0);
    assign frame_byte  = queue_reg[rd_ptr_reg].data;
    assign frame_first = queue_reg[rd_ptr_reg].first;
    assign frame_last  = queue_reg[rd_ptr_reg].last;
    assign frame_abort = queue_reg[rd_ptr_reg].abort;

endmodule

// ===== rtl/dfe_checker.sv =====
// Port-level checker for the delimited frame extractor.
// Watches the handshake and result ports only; bound to delimited_frame_extractor below.
module dfe_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [7:0]                    frame_byte,
    input  logic                          frame_first,
    input  logic                          frame_last,
    input  logic                          frame_abort
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte)
            && $stable(frame_first) && $stable(frame_last) && $stable(frame_abort))
        else $error("stalled result changed");

    // An abort carries no byte and no frame flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_abort |-> frame_byte == 8'd0 && !frame_first && !frame_last)
        else $error("abort result carries data");

    // A byte cannot both open and close a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_first && frame_last))
        else $error("head flagged as last");

    // Requests are refused only while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request refused with empty queue");

    // Nothing is offered once reset has been seen by a clock edge.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered during reset");

endmodule

bind delimited_frame_extractor dfe_checker u_dfe_checker (.*);

// ===== tb/tb_delimited_frame_extractor.sv =====
// Testbench for delimited_frame_extractor: a directed table, then random byte streams
// of well-formed, broken and noise sentences under several register settings.
// Depends on dfe_pkg and the RTL top. Results are checked against a built-in predictor.
module tb_delimited_frame_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    import dfe_pkg::*;

    localparam int QuietLimit   = 3000;
    localparam int HoldCycles   = 300;
    localparam int SettleCycles = 4;
    localparam int PhaseItems   = 140;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic       typed;
        logic [1:0] n_res;
        cfg_idx_t   reg_idx;
        logic [7:0] value;
        frame_res_t res0;
        frame_res_t res1;
    } dir_row_t;

    localparam frame_res_t NoRes     = '0;
    localparam frame_res_t DollarRes = '{8'h24, 1'b1, 1'b0, 1'b0};
    localparam frame_res_t LfLastRes = '{8'h0A, 1'b0, 1'b1, 1'b0};
    localparam frame_res_t ZeroHead  = '{8'h00, 1'b1, 1'b0, 1'b0};
    localparam frame_res_t ZeroLast  = '{8'h00, 1'b0, 1'b1, 1'b0};
    localparam frame_res_t ByteYRes  = '{8'h79, 1'b0, 1'b0, 1'b0};

    // The table covers bytes before a head, a good sentence, a head inside a frame,
    // a length limit below three, a completing tail byte that equals the head, a
    // register change inside a frame and a limit lowered below the frame length.
    localparam int DirRows = 35;
    localparam dir_row_t DirTable [DirRows] = '{
        '{ROW_BYTE, 1'b1, 2'd0, CFG_HEAD_CHAR,     8'h00, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h24, DollarRes, NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h47, NoRes,     NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h0D, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h0A, LfLastRes, NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h24, DollarRes, NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'hFF, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd2, CFG_HEAD_CHAR,     8'h24, AbortRes,  DollarRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h0D, NoRes,     NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h0D, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h0A, LfLastRes, NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_MAX_FRAME_LEN, 8'd0,  NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h24, DollarRes, NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h78, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd2, CFG_HEAD_CHAR,     8'h79, ByteYRes,  AbortRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h24, DollarRes, NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h0D, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h0A, LfLastRes, NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_HEAD_CHAR,     8'h00, NoRes,     NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_TAIL_FIRST,    8'hFF, NoRes,     NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_TAIL_SECOND,   8'h00, NoRes,     NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_MAX_FRAME_LEN, 8'd255, NoRes,    NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h00, ZeroHead,  NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'hFF, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h00, ZeroLast,  NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h00, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd2, CFG_HEAD_CHAR,     8'h00, AbortRes,  ZeroHead},
        '{ROW_CFG,  1'b0, 2'd0, CFG_HEAD_CHAR,     8'h24, NoRes,     NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_TAIL_SECOND,   8'h0A, NoRes,     NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_TAIL_FIRST,    8'h0D, NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd2, CFG_HEAD_CHAR,     8'h24, AbortRes,  DollarRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h61, NoRes,     NoRes},
        '{ROW_BYTE, 1'b0, 2'd0, CFG_HEAD_CHAR,     8'h0D, NoRes,     NoRes},
        '{ROW_CFG,  1'b0, 2'd0, CFG_MAX_FRAME_LEN, 8'd1,  NoRes,     NoRes},
        '{ROW_BYTE, 1'b1, 2'd1, CFG_HEAD_CHAR,     8'h0A, AbortRes,  NoRes}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] frame_byte;
    logic       frame_first;
    logic       frame_last;
    logic       frame_abort;
    logic       cfg_we = 1'b0;
    cfg_idx_t   cfg_index = CFG_HEAD_CHAR;
    logic [7:0] cfg_data = 8'h00;

    logic [7:0] head_chr  = HeadCharReset;
    logic [7:0] tail1_chr = TailFirstReset;
    logic [7:0] tail2_chr = TailSecondReset;
    logic [7:0] max_len   = MaxFrameLenReset;
    logic       in_frm      = 1'b0;
    logic       after_tail1 = 1'b0;
    logic [7:0] frm_len     = 8'd0;

    frame_res_t frame_q [$];

    logic       pin_on = 1'b0;
    logic [1:0] pin_n  = 2'd0;
    frame_res_t pin_r0 = '0;
    frame_res_t pin_r1 = '0;

    int send_gap_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int results_seen  = 0;

    delimited_frame_extractor i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_first(frame_first),
        .frame_last (frame_last),
        .frame_abort(frame_abort),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void drop_frame();
        in_frm      = 1'b0;
        frm_len     = 8'd0;
        after_tail1 = 1'b0;
    endfunction

    function automatic int cut_frame(input logic [7:0] b, output frame_res_t r0,
                                     output frame_res_t r1);
        int unsigned lim;
        int unsigned n;
        lim = 32'((max_len < MinFrameLen) ? MinFrameLen : max_len);
        n   = 32'(frm_len);
        r0  = '0;
        r1  = '0;
        if (!in_frm)
        begin
            if (b != head_chr)
                return 0;
            r0          = '{b, 1'b1, 1'b0, 1'b0};
            in_frm      = 1'b1;
            frm_len     = 8'd1;
            after_tail1 = 1'b0;
            return 1;
        end
        if (after_tail1 && b == tail2_chr && n + 1 <= lim)
        begin
            r0 = '{b, 1'b0, 1'b1, 1'b0};
            drop_frame();
            return 1;
        end
        if (b == head_chr)
        begin
            r0          = AbortRes;
            r1          = '{b, 1'b1, 1'b0, 1'b0};
            frm_len     = 8'd1;
            after_tail1 = 1'b0;
            return 2;
        end
        if (n >= lim)
        begin
            r0 = AbortRes;
            drop_frame();
            return 1;
        end
        r0          = '{b, 1'b0, 1'b0, 1'b0};
        n           = n + 1;
        frm_len     = n[7:0];
        after_tail1 = (b == tail1_chr);
        if (n >= lim)
        begin
            r1 = AbortRes;
            drop_frame();
            return 2;
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        frame_res_t want;
        frame_res_t r0;
        frame_res_t r1;
        int         n;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frame_q.size() == 0)
                    report_mismatch("result with nothing pending, frame_byte",
                                    int'(frame_byte), -1);
                else
                begin
                    want = frame_q.pop_front();
                    if (frame_byte !== want.data)
                        report_mismatch("frame_byte", int'(frame_byte), int'(want.data));
                    if (frame_first !== want.first)
                        report_mismatch("frame_first", int'(frame_first), int'(want.first));
                    if (frame_last !== want.last)
                        report_mismatch("frame_last", int'(frame_last), int'(want.last));
                    if (frame_abort !== want.abort)
                        report_mismatch("frame_abort", int'(frame_abort), int'(want.abort));
                end
                results_seen++;
            end
            if (in_valid && in_ready)
            begin
                n = cut_frame(rx_byte, r0, r1);
                if (pin_on)
                begin
                    n  = int'(pin_n);
                    r0 = pin_r0;
                    r1 = pin_r1;
                end
                if (n > 0)
                    frame_q.push_back(r0);
                if (n > 1)
                    frame_q.push_back(r1);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // The receiver owns the long hold-off countdown, so the sender keeps offering
    // requests while the result queue fills up.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic offer_byte(input logic [7:0] b, input logic pinned, input logic [1:0] n,
                              input frame_res_t r0, input frame_res_t r1);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        pin_on   = pinned;
        pin_n    = n;
        pin_r0   = r0;
        pin_r1   = r1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_HEAD_CHAR:     head_chr  = v;
            CFG_TAIL_FIRST:    tail1_chr = v;
            CFG_TAIL_SECOND:   tail2_chr = v;
            CFG_MAX_FRAME_LEN: max_len   = v;
            default:           ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] h, input logic [7:0] t1, input logic [7:0] t2,
                            input logic [7:0] m);
        write_reg(CFG_HEAD_CHAR, h);
        write_reg(CFG_TAIL_FIRST, t1);
        write_reg(CFG_TAIL_SECOND, t2);
        write_reg(CFG_MAX_FRAME_LEN, m);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // A sentence is the head, a body, and both tail bytes. Once in a while the body
    // is sized to land exactly on the length limit or just past it. A broken sentence
    // has one byte overwritten or is cut short.
    task automatic send_sentence(input bit broken, output int bytes);
        logic [7:0]  pkt [$];
        logic [7:0]  b;
        int unsigned lim;
        int unsigned body;
        int unsigned cut;
        lim = 32'((max_len < MinFrameLen) ? MinFrameLen : max_len);
        if ($urandom_range(19) == 0)
            body = lim - 3 + $urandom_range(0, 2);
        else
            body = $urandom_range(0, (lim - 3 < 12) ? lim - 3 : 12);
        pkt.push_back(head_chr);
        repeat (body)
        begin
            b = 8'($urandom_range(255));
            if (b == head_chr || b == tail1_chr)
                b = 8'($urandom_range(255));
            pkt.push_back(b);
        end
        pkt.push_back(tail1_chr);
        pkt.push_back(tail2_chr);
        if (broken)
        begin
            cut = $urandom_range(pkt.size() - 1);
            if ($urandom_range(1) == 0)
                pkt[cut] = 8'($urandom_range(255));
            else
                repeat (pkt.size() - cut - 1) void'(pkt.pop_back());
        end
        foreach (pkt[k])
            offer_byte(pkt[k], 1'b0, 2'd0, NoRes, NoRes);
        bytes = pkt.size();
    endtask

    task automatic run_phase(input int quota, input bit with_hold);
        int sent;
        int bytes;
        int roll;
        bit held;
        sent = 0;
        held = 1'b0;
        while (sent < quota)
        begin
            if (with_hold && !held && sent >= quota / 2)
            begin
                hold_left = HoldCycles;
                held      = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 85)
            begin
                send_sentence(roll >= 70, bytes);
                sent += bytes;
            end
            else
                repeat ($urandom_range(1, 4))
                    offer_byte(8'($urandom_range(255)), 1'b0, 2'd0, NoRes, NoRes);
        end
    endtask

    initial
    begin
        dir_row_t row;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_gap_pct  = 9;
        rcv_stall_pct = 76;
        for (int i = 0; i < DirRows; i++)
        begin
            row = DirTable[i];
            if (row.kind == ROW_CFG)
            begin
                drain_results();
                write_reg(row.reg_idx, row.value);
                @(negedge clk);
                cfg_we <= 1'b0;
            end
            else
                offer_byte(row.value, row.typed, row.n_res, row.res0, row.res1);
        end

        for (int p = 0; p < 6; p++)
        begin
            send_gap_pct  = (p / 2 == 0) ? 9 : (p / 2 == 1) ? 76 : 0;
            rcv_stall_pct = (p / 2 == 0) ? 76 : (p / 2 == 1) ? 9 : 0;
            drain_results();
            case (p)
                0: set_regs(HeadCharReset, TailFirstReset, TailSecondReset, MaxFrameLenReset);
                1: set_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(3, 24)));
                2: set_regs(8'hFF, 8'h00, 8'hFF, 8'd255);
                3: set_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(0, 5)));
                4: set_regs(HeadCharReset, TailFirstReset, TailSecondReset,
                            8'($urandom_range(6, 40)));
                default: set_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(3, 255)));
            endcase
            run_phase(PhaseItems, p == 4);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (frame_q.size() != 0)
            report_mismatch("results never delivered", 0, frame_q.size());
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
